### hdl/npz_pkg.sv
// ---------------------------------------------------------------------------
// npz_pkg
// shared types and constants of the neutrino pz solver
// ---------------------------------------------------------------------------
package npz_pkg;

    // reset value of the w mass register, in MeV
    localparam int W_MASS_RESET = 80379;

    // multiplier depth used for every npz_mul instance
    localparam int MUL_STAGES = 4;

    typedef enum logic [1:0] {
        ST_REAL    = 2'd0,
        ST_COMPLEX = 2'd1,
        ST_DEGEN   = 2'd2,
        ST_SAT     = 2'd3
    } t_solve_status;

endpackage

### hdl/npz_mul.sv
// ---------------------------------------------------------------------------
// npz_mul
// pipelined unsigned multiplier, one slice of the b operand per stage,
// with a tag that travels alongside the operands
// ---------------------------------------------------------------------------
module npz_mul
    import npz_pkg::*;
#(
    parameter int WA     = 16,
    parameter int WB     = 16,
    parameter int TW     = 1,
    parameter int STAGES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [WA-1:0]      i_a,
    input  logic [WB-1:0]      i_b,
    input  logic [TW-1:0]      i_tag,
    output logic               o_vld,
    output logic [WA+WB-1:0]   o_p,
    output logic [TW-1:0]      o_tag
);

    localparam int CH = (WB + STAGES - 1) / STAGES;
    localparam int BP = CH * STAGES;
    localparam int PW = WA + WB;

    typedef struct packed {
        logic [PW-1:0] acc;
        logic [WA-1:0] a;
        logic [BP-1:0] b;
        logic [TW-1:0] tag;
    } t_mst;

    t_mst          st [STAGES+1];
    logic [STAGES:0] v;

    assign st[0] = '{acc: '0, a: i_a, b: BP'(i_b), tag: i_tag};
    assign v[0]  = i_vld;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [WA+CH-1:0] pp;
        logic [PW-1:0]    pp_sh;
        t_mst             r_st;
        logic             r_v;

        assign pp    = (WA+CH)'(st[s].a) * (WA+CH)'(st[s].b[s*CH +: CH]);
        assign pp_sh = PW'(pp) << (s * CH);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st.acc <= st[s].acc + pp_sh;
                r_st.a   <= st[s].a;
                r_st.b   <= st[s].b;
                r_st.tag <= st[s].tag;
            end
        end

        assign st[s+1] = r_st;
        assign v[s+1]  = r_v;
    end

    assign o_vld = v[STAGES];
    assign o_p   = st[STAGES].acc;
    assign o_tag = st[STAGES].tag;

endmodule

### hdl/neutrino_pz_mass_constraint_top.sv
// ---------------------------------------------------------------------------
// neutrino_pz_mass_constraint_top
// neutrino longitudinal momentum from the w mass constraint quadratic
// ---------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  s (in)    in   i_s_tvalid / o_s_tready    i_s_tdata: lepton and missing momenta
//  m (out)   out  o_m_tvalid / i_m_tready    o_m_tdata: neutrino_pz, o_m_tuser: status
//  cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_data: w_mass
//
//  one item per cycle while the output buffer is not full; the square
//  root gives one root bit per stage and the divider one quotient bit
//  per stage
//  reset clears all valid bits, the output buffer and loads the w mass
//  a two-entry output buffer parts the pipeline from the consumer; the
//  whole pipeline holds while that buffer is full
// ---------------------------------------------------------------------------
module neutrino_pz_mass_constraint_top
    import npz_pkg::*;
#(
    parameter int MOMENTUM_BITS = 21
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // lepton_px, lepton_py, lepton_pz, lepton_energy, missing_px, missing_py,
    // missing_et
    input  logic [((7*MOMENTUM_BITS-2+7)/8)*8-1:0] i_s_tdata,
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    // neutrino_pz
    output logic [((MOMENTUM_BITS+2+7)/8)*8-1:0]    o_m_tdata,
    // solve_status
    output logic [1:0]                              o_m_tuser,
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    input  logic [MOMENTUM_BITS-2:0]                i_cfg_data,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready
);

    localparam int M    = MOMENTUM_BITS;
    localparam int EB   = M - 1;          // energy width
    localparam int PZW  = M + 2;          // result width
    localparam int OW   = ((PZW + 7) / 8) * 8;
    localparam int SXW  = M + 1;          // transverse sum width
    localparam int SQW  = 2 * SXW;        // square of transverse sum
    localparam int E2W  = 2 * EB;         // square of an energy
    localparam int AW   = 2 * M;          // signed a (quadratic coefficient / 4)
    localparam int AM   = 2 * M - 1;      // |a|
    localparam int KW   = 2 * M + 3;      // signed k
    localparam int KM   = KW - 1;         // |k|
    localparam int DW   = 4 * M + 6;      // signed discriminant
    localparam int SW   = DW / 2;         // root bits
    localparam int NW   = 3 * M + 4;      // signed numerator
    localparam int DVW  = AM + 1;         // divisor 2|a|
    localparam int RW   = DVW + 1;        // divider remainder
    localparam int HW   = NW - PZW + 1;   // quotient bits above the result range

    localparam int O_LPY = M;
    localparam int O_LPZ = 2 * M;
    localparam int O_E   = 3 * M;
    localparam int O_MPX = 4 * M - 1;
    localparam int O_MPY = 5 * M - 1;
    localparam int O_ET  = 6 * M - 1;

    // config register
    logic [EB-1:0] r_w_mass;

    // output buffer and pipeline enable
    logic [1:0] r_cnt;
    logic       en;

    assign o_cfg_ready = 1'b1;
    assign en          = (r_cnt != 2'd2);
    assign o_s_tready  = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_mass <= EB'(W_MASS_RESET);
        end else if (i_cfg_valid) begin
            r_w_mass <= i_cfg_data;
        end
    end

    // ---- stage 1: unpack, transverse sums ----
    logic [M-1:0]  in_lpx, in_lpy, in_lpz, in_mpx, in_mpy;
    logic [EB-1:0] in_e, in_et;

    assign in_lpx = i_s_tdata[0 +: M];
    assign in_lpy = i_s_tdata[O_LPY +: M];
    assign in_lpz = i_s_tdata[O_LPZ +: M];
    assign in_e   = i_s_tdata[O_E +: EB];
    assign in_mpx = i_s_tdata[O_MPX +: M];
    assign in_mpy = i_s_tdata[O_MPY +: M];
    assign in_et  = i_s_tdata[O_ET +: EB];

    logic                  r1_vld;
    logic signed [SXW-1:0] r1_sx, r1_sy;
    logic signed [M-1:0]   r1_lpz;
    logic [EB-1:0]         r1_e, r1_et;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sx  <= $signed({in_lpx[M-1], in_lpx}) + $signed({in_mpx[M-1], in_mpx});
            r1_sy  <= $signed({in_lpy[M-1], in_lpy}) + $signed({in_mpy[M-1], in_mpy});
            r1_lpz <= $signed(in_lpz);
            r1_e   <= in_e;
            r1_et  <= in_et;
        end
    end

    // ---- stage 2: squares ----
    logic signed [SQW-1:0] sx_sq, sy_sq;
    logic signed [2*M-1:0] pz_sq;
    logic [E2W-1:0]        e_sq, et_sq, w_sq;

    assign sx_sq = r1_sx * r1_sx;
    assign sy_sq = r1_sy * r1_sy;
    assign pz_sq = r1_lpz * r1_lpz;
    assign e_sq  = r1_e * r1_e;
    assign et_sq = r1_et * r1_et;
    assign w_sq  = r_w_mass * r_w_mass;

    logic                r2_vld;
    logic [SQW-1:0]      r2_sx2, r2_sy2;
    logic [AM-1:0]       r2_pz2;
    logic [E2W-1:0]      r2_e2, r2_et2, r2_w2;
    logic signed [M-1:0] r2_lpz;
    logic [EB-1:0]       r2_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sx2 <= sx_sq;
            r2_sy2 <= sy_sq;
            r2_pz2 <= pz_sq[AM-1:0];
            r2_e2  <= e_sq;
            r2_et2 <= et_sq;
            r2_w2  <= w_sq;
            r2_lpz <= r1_lpz;
            r2_e   <= r1_e;
        end
    end

    // ---- stage 3: partial sums of k, coefficient a ----
    logic [KW-1:0] p_n, q_n;
    logic [AW-1:0] a_n;

    assign p_n = KW'(r2_e2) + KW'(r2_et2) - KW'(r2_w2);
    assign q_n = KW'(r2_sx2) + KW'(r2_sy2) + KW'(r2_pz2);
    assign a_n = AW'(r2_e2) - AW'(r2_pz2);

    logic                r3_vld;
    logic [KW-1:0]       r3_p, r3_q;
    logic [AW-1:0]       r3_a;
    logic signed [M-1:0] r3_lpz;
    logic [EB-1:0]       r3_e;
    logic [E2W-1:0]      r3_et2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_p   <= p_n;
            r3_q   <= q_n;
            r3_a   <= a_n;
            r3_lpz <= r2_lpz;
            r3_e   <= r2_e;
            r3_et2 <= r2_et2;
        end
    end

    // ---- stage 4: k, |a| ----
    logic                r4_vld;
    logic [KW-1:0]       r4_k;
    logic [AM-1:0]       r4_aabs;
    logic                r4_asign, r4_degen;
    logic signed [M-1:0] r4_lpz;
    logic [EB-1:0]       r4_e;
    logic [E2W-1:0]      r4_et2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_k     <= r3_p - r3_q;
            r4_aabs  <= r3_a[AW-1] ? AM'(-r3_a) : AM'(r3_a);
            r4_asign <= r3_a[AW-1];
            r4_degen <= (r3_a == '0);
            r4_lpz   <= r3_lpz;
            r4_e     <= r3_e;
            r4_et2   <= r3_et2;
        end
    end

    // ---- stage 5: magnitudes for the multipliers ----
    typedef struct packed {
        logic          degen;
        logic [EB-1:0] e;
        logic [AM-1:0] aabs;
    } t_m1side;

    logic           r5_vld;
    logic [KM-1:0]  r5_kabs;
    logic [M-1:0]   r5_lpzabs;
    logic           r5_bneg;
    logic           r5_asign;
    logic [E2W-1:0] r5_et2;
    t_m1side        r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_kabs   <= r4_k[KW-1] ? KM'(-r4_k) : KM'(r4_k);
            r5_lpzabs <= r4_lpz[M-1] ? M'(-r4_lpz) : M'(r4_lpz);
            // base = -k*lpz is negative when k and lpz share a sign
            r5_bneg   <= ~(r4_k[KW-1] ^ r4_lpz[M-1]);
            r5_asign  <= r4_asign;
            r5_et2    <= r4_et2;
            r5_side   <= '{degen: r4_degen, e: r4_e, aabs: r4_aabs};
        end
    end

    // ---- k^2, |a|*et^2 and |k*lpz| ----
    logic                 kk_v, ae_v, kl_v;
    logic [2*KM-1:0]      kk_p;
    logic [AM+E2W-1:0]    ae_p;
    logic [KM+M-1:0]      kl_p;
    logic [$bits(t_m1side)-1:0] kk_tag;
    logic                 ae_tag, kl_tag;

    npz_mul #(.WA(KM), .WB(KM), .TW($bits(t_m1side)), .STAGES(MUL_STAGES)) u_mul_kk (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_vld (r5_vld),
        .i_a (r5_kabs), .i_b (r5_kabs), .i_tag (r5_side),
        .o_vld (kk_v), .o_p (kk_p), .o_tag (kk_tag)
    );

    npz_mul #(.WA(AM), .WB(E2W), .TW(1), .STAGES(MUL_STAGES)) u_mul_ae (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_vld (r5_vld),
        .i_a (r5_side.aabs), .i_b (r5_et2), .i_tag (r5_asign),
        .o_vld (ae_v), .o_p (ae_p), .o_tag (ae_tag)
    );

    npz_mul #(.WA(KM), .WB(M), .TW(1), .STAGES(MUL_STAGES)) u_mul_kl (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_vld (r5_vld),
        .i_a (r5_kabs), .i_b (r5_lpzabs), .i_tag (r5_bneg),
        .o_vld (kl_v), .o_p (kl_p), .o_tag (kl_tag)
    );

    // ---- stage 6: discriminant and base numerator ----
    typedef struct packed {
        logic          degen;
        logic          dneg;
        logic          asign;
        logic [AM-1:0] aabs;
        logic [EB-1:0] e;
        logic [NW-1:0] base;
    } t_sqside;

    t_m1side       m1_side;
    logic [DW-1:0] ae4;
    logic [DW-1:0] d_n;
    logic [NW-1:0] b_n;

    assign m1_side = kk_tag;
    assign ae4     = DW'({ae_p, 2'b00});
    // d = k^2 - 4*a*et^2
    assign d_n     = ae_tag ? DW'(kk_p) + ae4 : DW'(kk_p) - ae4;
    assign b_n     = kl_tag ? -NW'(kl_p) : NW'(kl_p);

    logic          r6_vld;
    logic [DW-1:0] r6_rad;
    t_sqside       r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= kk_v & ae_v & kl_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // negative discriminant: root forced to zero, real part only
            r6_rad  <= d_n[DW-1] ? '0 : d_n;
            r6_side <= '{degen: m1_side.degen, dneg: d_n[DW-1], asign: ae_tag,
                         aabs: m1_side.aabs, e: m1_side.e, base: b_n};
        end
    end

    // ---- integer square root, one root bit per stage ----
    typedef struct packed {
        logic [SW+1:0]   rem;
        logic [SW-1:0]   root;
        logic [2*SW-1:0] rad;
        t_sqside         side;
    } t_sqst;

    t_sqst       sq_s [SW+1];
    logic [SW:0] sq_v;

    assign sq_s[0] = '{rem: '0, root: '0, rad: r6_rad, side: r6_side};
    assign sq_v[0] = r6_vld;

    for (genvar j = 0; j < SW; j++) begin : g_sqrt
        logic [SW+1:0] cur, trial;
        logic          ge;
        t_sqst         r_st;
        logic          r_v;

        assign cur   = {sq_s[j].rem[SW-1:0], sq_s[j].rad[2*SW-1 -: 2]};
        assign trial = {sq_s[j].root, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (en) begin
                r_v <= sq_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_st.rem  <= ge ? cur - trial : cur;
                r_st.root <= {sq_s[j].root[SW-2:0], ge};
                r_st.rad  <= sq_s[j].rad << 2;
                r_st.side <= sq_s[j].side;
            end
        end

        assign sq_s[j+1] = r_st;
        assign sq_v[j+1] = r_v;
    end

    // ---- e * sqrt(d) ----
    typedef struct packed {
        logic          degen;
        logic          dneg;
        logic          asign;
        logic [AM-1:0] aabs;
        logic [NW-1:0] base;
    } t_esside;

    t_sqside              sq_out;
    t_esside              es_in_side, es_side;
    logic                 es_v;
    logic [SW+EB-1:0]     es_p;
    logic [$bits(t_esside)-1:0] es_tag;

    assign sq_out     = sq_s[SW].side;
    assign es_in_side = '{degen: sq_out.degen, dneg: sq_out.dneg, asign: sq_out.asign,
                          aabs: sq_out.aabs, base: sq_out.base};

    npz_mul #(.WA(SW), .WB(EB), .TW($bits(t_esside)), .STAGES(MUL_STAGES)) u_mul_es (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_vld (sq_v[SW]),
        .i_a (sq_s[SW].root), .i_b (sq_out.e), .i_tag (es_in_side),
        .o_vld (es_v), .o_p (es_p), .o_tag (es_tag)
    );

    assign es_side = es_tag;

    // ---- stage 7: root of smaller magnitude, plus root on a tie ----
    logic          base_pos;
    logic [NW-1:0] num_n;

    assign base_pos = !es_side.base[NW-1] && (es_side.base != '0);
    assign num_n    = base_pos ? es_side.base - NW'(es_p) : es_side.base + NW'(es_p);

    typedef struct packed {
        logic          degen;
        logic          dneg;
        logic          asign;
        logic [AM-1:0] aabs;
    } t_nside;

    logic          r7_vld;
    logic [NW-1:0] r7_num;
    t_nside        r7_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= es_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_num  <= num_n;
            r7_side <= '{degen: es_side.degen, dneg: es_side.dneg,
                         asign: es_side.asign, aabs: es_side.aabs};
        end
    end

    // ---- stage 8: |num| and quotient sign ----
    logic          r8_vld;
    logic [NW-1:0] r8_nabs;
    logic          r8_qs;
    t_nside        r8_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (en) begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_nabs <= r7_num[NW-1] ? -r7_num : r7_num;
            r8_qs   <= r7_num[NW-1] ^ r7_side.asign;
            r8_side <= r7_side;
        end
    end

    // ---- stage 9: rounding offset, (|num| + |a|) / (2|a|) ----
    typedef struct packed {
        logic degen;
        logic dneg;
        logic qs;
    } t_qside;

    logic           r9_vld;
    logic [NW-1:0]  r9_u;
    logic [DVW-1:0] r9_dv;
    t_qside         r9_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else if (en) begin
            r9_vld <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_u    <= r8_nabs + NW'(r8_side.aabs);
            r9_dv   <= {r8_side.aabs, 1'b0};
            r9_side <= '{degen: r8_side.degen, dneg: r8_side.dneg, qs: r8_qs};
        end
    end

    // ---- restoring divider, one quotient bit per stage ----
    typedef struct packed {
        logic [RW-1:0]  rem;
        logic [NW-1:0]  u;
        logic [NW-1:0]  q;
        logic [DVW-1:0] dv;
        t_qside         side;
    } t_dvst;

    t_dvst       dv_s [NW+1];
    logic [NW:0] dv_v;

    assign dv_s[0] = '{rem: '0, u: r9_u, q: '0, dv: r9_dv, side: r9_side};
    assign dv_v[0] = r9_vld;

    for (genvar i = 0; i < NW; i++) begin : g_div
        logic [RW-1:0] cur;
        logic          ge;
        t_dvst         r_st;
        logic          r_v;

        assign cur = {dv_s[i].rem[DVW-1:0], dv_s[i].u[NW-1]};
        assign ge  = (cur >= RW'(dv_s[i].dv));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (en) begin
                r_v <= dv_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_st.rem  <= ge ? cur - RW'(dv_s[i].dv) : cur;
                r_st.u    <= dv_s[i].u << 1;
                r_st.q    <= {dv_s[i].q[NW-2:0], ge};
                r_st.dv   <= dv_s[i].dv;
                r_st.side <= dv_s[i].side;
            end
        end

        assign dv_s[i+1] = r_st;
        assign dv_v[i+1] = r_v;
    end

    // ---- stage 10: sign, saturation and status ----
    typedef struct packed {
        t_solve_status status;
        logic [PZW-1:0] pz;
    } t_res;

    localparam logic [PZW-1:0] PZ_MAX = {1'b0, {(PZW-1){1'b1}}};
    localparam logic [PZW-1:0] PZ_MIN = {1'b1, {(PZW-1){1'b0}}};

    logic [NW-1:0] q_fin;
    logic [HW-1:0] q_hi;
    logic          qneg, over;
    t_qside        q_side;
    t_res          res_n;

    assign q_fin  = dv_s[NW].q;
    assign q_hi   = q_fin[NW-1:PZW-1];
    assign q_side = dv_s[NW].side;
    assign qneg   = q_side.qs && (q_fin != '0);
    // the negative limit is one step further out than the positive one
    assign over   = (q_hi != '0) &&
                    !(qneg && (q_hi == HW'(1)) && (q_fin[PZW-2:0] == '0));

    always_comb begin
        res_n.pz     = qneg ? -q_fin[PZW-1:0] : q_fin[PZW-1:0];
        res_n.status = q_side.dneg ? ST_COMPLEX : ST_REAL;
        if (q_side.degen) begin
            res_n.pz     = '0;
            res_n.status = ST_DEGEN;
        end else if (over) begin
            res_n.pz     = qneg ? PZ_MIN : PZ_MAX;
            res_n.status = ST_SAT;
        end
    end

    logic r10_vld;
    t_res r10_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else if (en) begin
            r10_vld <= dv_v[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_res <= res_n;
        end
    end

    // ---- two-entry output buffer ----
    t_res r_ob0, r_ob1;
    logic push, pop;

    assign push = en && r10_vld;
    assign pop  = (r_cnt != 2'd0) && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && (r_cnt == 2'd2)) begin
            r_ob0 <= r_ob1;
        end
        if (push && ((r_cnt == 2'd0) || pop)) begin
            r_ob0 <= r10_res;
        end
        if (push && (r_cnt == 2'd1) && !pop) begin
            r_ob1 <= r10_res;
        end
    end

    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = OW'(r_ob0.pz);
    assign o_m_tuser  = r_ob0.status;

    // ---- assertions ----
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ST_DEGEN)) |-> (o_m_tdata[PZW-1:0] == '0))
        else $error("degenerate item with nonzero pz");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ST_SAT)) |->
        ((o_m_tdata[PZW-1:0] == PZ_MAX) || (o_m_tdata[PZW-1:0] == PZ_MIN)))
        else $error("saturated item not at a limit");

    a_buf_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |=> (r_cnt != 2'd0))
        else $error("output buffer lost an item");

endmodule

### tb/neutrino_pz_mass_constraint_top_test.sv
// ---------------------------------------------------------------------------
// neutrino_pz_mass_constraint_top_test
// self-checking bench for the neutrino pz solver: a directed table of events, then
// random events under several w mass settings, each result compared with its row's
// typed result or an exact wide-integer solution of the w mass constraint quadratic
// ---------------------------------------------------------------------------
module neutrino_pz_mass_constraint_top_test
    import npz_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MB       = 21;
    localparam int IN_W     = ((7*MB-2+7)/8)*8;
    localparam int OUT_W    = ((MB+2+7)/8)*8;
    localparam int LATENCY  = 5*MB+26;
    localparam int N_RANDOM = 1680;
    localparam int HOLD_CYC = 400;

    typedef struct {
        int lpx, lpy, lpz, e, mpx, mpy, et;
    } t_event;

    typedef struct packed {
        logic [MB+1:0] pz;
        t_solve_status status;
    } t_pz_sol;

    typedef struct {
        t_event  ev;
        bit      typed;
        t_pz_sol sol;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic [IN_W-1:0]   i_s_tdata;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [OUT_W-1:0]  o_m_tdata;
    logic [1:0]        o_m_tuser;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [MB-2:0]     i_cfg_data;
    logic              i_cfg_valid;
    logic              o_cfg_ready;

    t_pz_sol       pz_expected[$];
    logic [MB-2:0] w_mass_shadow;
    int            n_errors;
    bit            typed_now;
    t_pz_sol       typed_sol;
    bit            hold_req;
    bit            no_gaps;

    neutrino_pz_mass_constraint_top #(.MOMENTUM_BITS(MB)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("neutrino_pz_mass_constraint_top_test: done, errors");
        $finish;
    end

    // ---- exact solver -------------------------------------------------------
    function automatic logic signed [127:0] mag(logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    // floor square root, one result bit per pass
    function automatic logic [127:0] floor_sqrt(logic [127:0] n);
        logic [127:0] res, bitv;
        res  = '0;
        bitv = 128'd1 << 126;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_pz_sol solve_pz(logic [IN_W-1:0] d, logic [MB-2:0] wm);
        logic signed [127:0] lpx, lpy, lpz, e, mpx, mpy, et, w;
        logic signed [127:0] sx, sy, k, a, disc, base, es, np, nm, num, den, q, lim;
        t_solve_status       status;
        bit                  qneg;
        t_pz_sol             r;
        lpx = $signed(d[20:0]);
        lpy = $signed(d[41:21]);
        lpz = $signed(d[62:42]);
        e   = {108'd0, d[82:63]};
        mpx = $signed(d[103:83]);
        mpy = $signed(d[124:104]);
        et  = {108'd0, d[144:125]};
        w   = {108'd0, wm};
        sx  = lpx + mpx;
        sy  = lpy + mpy;
        k   = e*e + et*et - sx*sx - sy*sy - lpz*lpz - w*w;
        a   = e*e - lpz*lpz;
        if (a == 0) begin
            r.pz     = '0;
            r.status = ST_DEGEN;
            return r;
        end
        disc = k*k - 4*a*et*et;
        base = -(k*lpz);
        if (disc < 0) begin
            num    = base;
            status = (e != 0) ? ST_COMPLEX : ST_REAL;
        end else begin
            es     = e * $signed(floor_sqrt(disc));
            np     = base + es;
            nm     = base - es;
            // smaller magnitude wins, ties to the plus root
            num    = (mag(np) > mag(nm)) ? nm : np;
            status = ST_REAL;
        end
        den  = 2*mag(a);
        q    = (2*mag(num) + den) / (2*den);
        qneg = ((num < 0) != (a < 0)) && (q != 0);
        lim  = (128'sd1 <<< (MB+1)) - 1 + (qneg ? 1 : 0);
        if (q > lim) begin
            q      = lim;
            status = ST_SAT;
        end
        r.pz     = qneg ? -q[MB+1:0] : q[MB+1:0];
        r.status = status;
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_event(t_event ev);
        return {7'd0, ev.et[19:0], ev.mpy[20:0], ev.mpx[20:0], ev.e[19:0],
                ev.lpz[20:0], ev.lpy[20:0], ev.lpx[20:0]};
    endfunction

    // ---- monitor: predict on input items, check output items -----------------
    always @(posedge i_clk) begin
        t_pz_sol exp_sol;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            pz_expected.push_back(typed_now ? typed_sol : solve_pz(i_s_tdata, w_mass_shadow));
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pz_expected.size() == 0) begin
                $display("%0t: unexpected item pz=%h status=%0d", $time,
                         o_m_tdata, o_m_tuser);
                n_errors++;
            end else begin
                exp_sol = pz_expected.pop_front();
                if (o_m_tdata != OUT_W'(exp_sol.pz)) begin
                    $display("%0t: pz expected %h actual %h", $time, exp_sol.pz, o_m_tdata);
                    n_errors++;
                end
                if (o_m_tuser != exp_sol.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_sol.status, o_m_tuser);
                    n_errors++;
                end
            end
        end
    end

    // ---- receiver: random back pressure, one long hold-off on request ------
    initial begin
        int r;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_tready = 1'b0;
                repeat (HOLD_CYC) @(negedge i_clk);
                hold_req = 1'b0;
            end
            r = $urandom_range(0, 99);
            if (no_gaps || r < 70) begin
                i_m_tready = 1'b1;
            end else if (r < 95) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge i_clk);
            end else begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge i_clk);
            end
        end
    end

    // ---- sender helpers -------------------------------------------------------
    task automatic send_event(t_event ev, bit typed, t_pz_sol sol);
        int r;
        @(negedge i_clk);
        typed_now  = typed;
        typed_sol  = sol;
        i_s_tdata  = pack_event(ev);
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        // gap after the item; valid stays high when there is none
        r = $urandom_range(0, 99);
        if (!no_gaps && r >= 60) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            i_s_tdata  = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
            if (r < 95) repeat ($urandom_range(0, 3)) @(negedge i_clk);
            else repeat ($urandom_range(10, 40)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pz_expected.size() != 0) @(posedge i_clk);
    endtask

    // config writes only with the pipeline empty
    task automatic write_w_mass(logic [MB-2:0] wm);
        drain();
        @(negedge i_clk);
        i_cfg_data  = wm;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid   = 1'b0;
        w_mass_shadow = wm;
    endtask

    function automatic int rand_mom(int span);
        return $urandom_range(0, 2*span) - span;
    endfunction

    function automatic t_event rand_event();
        t_event ev;
        int     kind;
        int     ae;
        kind   = $urandom_range(0, 99);
        ev.lpx = rand_mom(60000);
        ev.lpy = rand_mom(60000);
        ev.lpz = rand_mom(200000);
        ev.mpx = rand_mom(60000);
        ev.mpy = rand_mom(60000);
        ev.et  = $urandom_range(0, 100000);
        ae     = ev.lpz < 0 ? -ev.lpz : ev.lpz;
        ev.e   = ae + $urandom_range(0, 40000);
        if (kind < 15) begin
            // full range noise on every field
            ev.lpx = rand_mom(1048576) < 1048576 ? rand_mom(1048576) : 1048575;
            ev.lpy = $urandom_range(0, 2097151) - 1048576;
            ev.lpz = $urandom_range(0, 2097151) - 1048576;
            ev.mpx = $urandom_range(0, 2097151) - 1048576;
            ev.mpy = $urandom_range(0, 2097151) - 1048576;
            ev.e   = $urandom_range(0, 1048575);
            ev.et  = $urandom_range(0, 1048575);
        end else if (kind < 20) begin
            ev.e = ae;                     // degenerate quadratic
        end else if (kind < 24) begin
            ev.e = 0;                      // zero lepton energy
        end else if (kind < 30) begin
            ev.e = ae + $urandom_range(0, 3);  // tiny a, tends to saturate
        end
        if (ev.e > 1048575) ev.e = 1048575;
        return ev;
    endfunction

    // ---- directed table --------------------------------------------------------
    localparam int N_ROWS = 14;
    t_row dir_rows[N_ROWS];

    initial begin
        dir_rows[0]  = '{'{0, 0, 0, 0, 0, 0, 0}, 1, '{'0, ST_DEGEN}};
        dir_rows[1]  = '{'{100, -200, 5000, 5000, 3, 4, 9000}, 1, '{'0, ST_DEGEN}};
        dir_rows[2]  = '{'{0, 0, -1048576, 0, 0, 0, 0}, 0, '{'0, ST_REAL}};
        dir_rows[3]  = '{'{1048575, 1048575, 1048575, 1048575, 1048575, 1048575,
                           1048575}, 1, '{'0, ST_DEGEN}};
        dir_rows[4]  = '{'{-1048576, -1048576, -1048576, 1048575, -1048576, -1048576,
                           1048575}, 0, '{'0, ST_REAL}};
        dir_rows[5]  = '{'{1048575, -1048576, 1048574, 1048575, -1048576, 1048575,
                           0}, 0, '{'0, ST_REAL}};
        dir_rows[6]  = '{'{30000, 10000, 20000, 40000, -25000, -5000, 26000}, 0,
                         '{'0, ST_REAL}};
        dir_rows[7]  = '{'{30000, 0, 0, 30000, 30000, 0, 30000}, 0, '{'0, ST_REAL}};
        dir_rows[8]  = '{'{1000, 0, 400000, 400001, 1000, 0, 500}, 0, '{'0, ST_REAL}};
        dir_rows[9]  = '{'{0, 0, 1000, 0, 0, 0, 5000}, 0, '{'0, ST_REAL}};
        dir_rows[10] = '{'{20000, 20000, -50000, 60000, -10000, 15000, 18000}, 0,
                         '{'0, ST_REAL}};
        dir_rows[11] = '{'{1, 1, 1, 1, 1, 1, 1}, 1, '{'0, ST_DEGEN}};
        dir_rows[12] = '{'{-1, -1, -1, 2, -1, -1, 0}, 0, '{'0, ST_REAL}};
        dir_rows[13] = '{'{0, 0, 1048575, 1048575, 0, 0, 0}, 1, '{'0, ST_DEGEN}};
    end

    // ---- main sequence -------------------------------------------------------
    initial begin
        logic [MB-2:0] masses[5];
        t_event        ev;
        t_pz_sol       none;
        int            per_phase;
        none          = '{'0, ST_REAL};
        n_errors      = 0;
        typed_now     = 1'b0;
        typed_sol     = none;
        hold_req      = 1'b0;
        no_gaps       = 1'b0;
        w_mass_shadow = (MB-1)'(W_MASS_RESET);
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows under the reset mass, then rows 6 to 9 under both mass extremes
        for (int i = 0; i < N_ROWS; i++)
            send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].sol);
        write_w_mass('0);
        for (int i = 0; i < 4; i++) send_event(dir_rows[i+6].ev, 0, none);
        write_w_mass({(MB-1){1'b1}});
        for (int i = 0; i < 4; i++) send_event(dir_rows[i+6].ev, 0, none);

        masses[0] = (MB-1)'(W_MASS_RESET);
        masses[1] = (MB-1)'($urandom_range(0, 200000));
        masses[2] = '0;
        masses[3] = {(MB-1){1'b1}};
        masses[4] = (MB-1)'(91188);
        per_phase = N_RANDOM / 5;
        for (int p = 0; p < 5; p++) begin
            write_w_mass(masses[p]);
            for (int i = 0; i < per_phase; i++) begin
                if (p == 1 && i == 20) hold_req = 1'b1;   // receiver stalls, pipe fills
                if (p == 2 && i == 100) drain();          // sender waits for all items
                no_gaps = (p == 3 && i >= 50 && i < 150); // full-rate stretch
                ev = rand_event();
                send_event(ev, 0, none);
            end
            no_gaps = 1'b0;
        end

        drain();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_errors == 0 && pz_expected.size() == 0) begin
            $display("neutrino_pz_mass_constraint_top_test: done, clean");
        end else begin
            $display("neutrino_pz_mass_constraint_top_test: done, errors");
        end
        $finish;
    end

endmodule
